>>> rtl/anf_pkg.sv
package anf_pkg;

	localparam int DATA_W             = 16;
	localparam int Y_W                = 24;
	localparam int MIX_W              = 15;
	localparam int MIX_FRAC           = 14;
	localparam int MIX_ONE            = 16384;
	localparam int COEF_FRAC_BITS_DEF = 14;
	localparam int OPA_W              = 25;
	localparam int T_W                = 41;
	localparam int T_SPLIT            = 20;
	localparam int STEP_W             = 4;
	localparam int CFG_IDX_W          = 2;
	localparam int Y_MAX              = 8388607;
	localparam int Y_MIN              = -8388608;
	localparam int S_MAX              = 32767;
	localparam int S_MIN              = -32768;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_C  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_D  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WET_MIX = 2'd2;

	localparam logic signed [DATA_W-1:0] COEF_C_RST  = -16'sd14202;
	localparam logic signed [DATA_W-1:0] COEF_D_RST  = -16'sd16202;
	localparam logic [MIX_W-1:0]         WET_MIX_RST = 15'd16384;

	typedef enum logic [2:0] {
		A_NONE, A_XDIFF, A_XSUM, A_TLO, A_THI, A_Y2, A_Y, A_X0
	} asel_t;

	typedef enum logic [2:0] {
		B_NONE, B_D, B_A, B_C, B_M, B_MINV
	} bsel_t;

	typedef enum logic [2:0] {
		P_NONE, P_LOAD_T, P_INIT_F, P_INIT_M, P_ADD
	} pact_t;

	typedef enum logic [2:0] {
		SH_0, SH_1, SH_T, SH_F, SH_F1
	} sh_t;

	typedef enum logic [1:0] {
		J_NEXT, J_WAIT, J_OUT, J_RST
	} jmp_t;

	typedef struct packed {
		asel_t asel;
		bsel_t bsel;
		pact_t pact;
		sh_t   sh;
		logic  yset;
		jmp_t  jmp;
	} ctrl_t;

	typedef struct packed {
		logic in_req;
		logic out_free;
	} seq_stat_t;

endpackage

>>> rtl/anf_seq.sv
module anf_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  anf_pkg::seq_stat_t stat,
	output anf_pkg::ctrl_t     ctrl
);
	import anf_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;

	function automatic ctrl_t rom(input logic [STEP_W-1:0] s);
		ctrl_t w;
		w = '{asel: A_NONE, bsel: B_NONE, pact: P_NONE, sh: SH_0, yset: 1'b0, jmp: J_NEXT};
		case (s)
			4'd0: w.jmp = J_WAIT;
			4'd1: begin w.asel = A_XDIFF; w.bsel = B_D;    w.pact = P_LOAD_T; end
			4'd2: begin w.asel = A_XSUM;  w.bsel = B_A;    w.pact = P_INIT_F; w.sh = SH_F;  end
			4'd3: begin w.asel = A_TLO;   w.bsel = B_A;    w.pact = P_ADD;    w.sh = SH_1;  end
			4'd4: begin w.asel = A_THI;   w.bsel = B_A;    w.pact = P_ADD;    w.sh = SH_T;  end
			4'd5: begin w.asel = A_Y2;    w.bsel = B_C;    w.pact = P_ADD;    w.sh = SH_F1; end
			4'd6: begin w.asel = A_X0;    w.bsel = B_MINV; w.pact = P_INIT_M; end
			4'd7: w.yset = 1'b1;
			4'd8: begin w.asel = A_Y;     w.bsel = B_M;    w.pact = P_ADD;    end
			4'd9: w.jmp = J_NEXT;
			4'd10: w.jmp = J_OUT;
			default: w.jmp = J_RST;
		endcase
		return w;
	endfunction

	assign ctrl = rom(step_q);

	always_comb begin
		step_d = step_q;
		case (ctrl.jmp)
			J_NEXT: step_d = step_q + 1'b1;
			J_WAIT: if (stat.in_req) step_d = step_q + 1'b1;
			J_OUT:  if (stat.out_free) step_d = '0;
			J_RST:  step_d = '0;
			default: step_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

>>> rtl/anf_dp.sv
module anf_dp #(
	parameter int F = anf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  anf_pkg::ctrl_t                      ctrl,
	input  logic                                in_fire,
	input  logic signed [anf_pkg::DATA_W-1:0]   sample_in,
	input  logic signed [anf_pkg::DATA_W-1:0]   coef_c,
	input  logic signed [anf_pkg::DATA_W-1:0]   coef_d,
	input  logic        [anf_pkg::MIX_W-1:0]    wet_mix,
	input  logic                                out_take,
	output logic signed [anf_pkg::DATA_W-1:0]   sample_out,
	output logic                                out_valid,
	output logic                                out_free
);
	import anf_pkg::*;

	localparam int AW   = ((F > DATA_W) ? F : DATA_W) + 2;
	localparam int PW   = OPA_W + AW;
	localparam int ACCW = AW + 44;

	localparam logic signed [AW-1:0]   ONE_A = AW'(1) << F;
	localparam logic signed [ACCW-1:0] RND_F = ACCW'(1) << (2 * F);
	localparam logic signed [ACCW-1:0] RND_M = ACCW'(1) << (MIX_FRAC - 1);
	localparam logic signed [ACCW-1:0] Y_HI  = ACCW'(Y_MAX);
	localparam logic signed [ACCW-1:0] Y_LO  = ACCW'(Y_MIN);
	localparam logic signed [ACCW-1:0] S_HI  = ACCW'(S_MAX);
	localparam logic signed [ACCW-1:0] S_LO  = ACCW'(S_MIN);

	logic signed [DATA_W-1:0] x0_q, x1_q, x2_q;
	logic signed [Y_W-1:0]    y_q, y1_q, y2_q;
	logic signed [T_W-1:0]    t_q;
	logic signed [ACCW-1:0]   acc_q;
	logic signed [PW-1:0]     prod_s1;
	pact_t                    pact_s1;
	sh_t                      sh_s1;
	logic signed [DATA_W-1:0] out_q;
	logic                     out_valid_q;

	logic signed [AW-1:0]     a_val;
	logic        [MIX_W-1:0]  m_val, minv_val;
	logic signed [OPA_W-1:0]  op_a;
	logic signed [AW-1:0]     op_b;
	logic signed [ACCW-1:0]   prod_ext, prod_sh;
	logic signed [ACCW-1:0]   y_full, s_full;
	logic signed [Y_W-1:0]    y_cl;
	logic signed [DATA_W-1:0] s_cl;
	logic                     out_go;

	assign a_val    = ONE_A - AW'(coef_c);
	assign m_val    = (wet_mix > MIX_W'(MIX_ONE)) ? MIX_W'(MIX_ONE) : wet_mix;
	assign minv_val = MIX_W'(MIX_ONE) - m_val;

	always_comb begin
		case (ctrl.asel)
			A_XDIFF: op_a = OPA_W'(x1_q) - OPA_W'(y1_q);
			A_XSUM:  op_a = OPA_W'(x0_q) + OPA_W'(x2_q);
			A_TLO:   op_a = $signed({{(OPA_W - T_SPLIT){1'b0}}, t_q[T_SPLIT-1:0]});
			A_THI:   op_a = OPA_W'($signed(t_q[T_W-1:T_SPLIT]));
			A_Y2:    op_a = OPA_W'(y2_q);
			A_Y:     op_a = OPA_W'(y_q);
			A_X0:    op_a = OPA_W'(x0_q);
			default: op_a = '0;
		endcase
	end

	always_comb begin
		case (ctrl.bsel)
			B_D:     op_b = AW'(coef_d);
			B_A:     op_b = a_val;
			B_C:     op_b = AW'(coef_c);
			B_M:     op_b = $signed({{(AW - MIX_W){1'b0}}, m_val});
			B_MINV:  op_b = $signed({{(AW - MIX_W){1'b0}}, minv_val});
			default: op_b = '0;
		endcase
	end

	assign prod_ext = ACCW'(prod_s1);

	always_comb begin
		case (sh_s1)
			SH_1:    prod_sh = prod_ext <<< 1;
			SH_T:    prod_sh = prod_ext <<< (T_SPLIT + 1);
			SH_F:    prod_sh = prod_ext <<< F;
			SH_F1:   prod_sh = prod_ext <<< (F + 1);
			default: prod_sh = prod_ext;
		endcase
	end

	// round half up, then saturate
	always_comb begin
		y_full = acc_q >>> (2 * F + 1);
		if (y_full > Y_HI)
			y_cl = Y_W'(Y_HI);
		else if (y_full < Y_LO)
			y_cl = Y_W'(Y_LO);
		else
			y_cl = y_full[Y_W-1:0];
		s_full = acc_q >>> MIX_FRAC;
		if (s_full > S_HI)
			s_cl = DATA_W'(S_HI);
		else if (s_full < S_LO)
			s_cl = DATA_W'(S_LO);
		else
			s_cl = s_full[DATA_W-1:0];
	end

	assign out_free = !out_valid_q || out_take;
	assign out_go   = (ctrl.jmp == J_OUT) && out_free;

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(op_a) * PW'(op_b);
		case (pact_s1)
			P_LOAD_T: t_q   <= T_W'(prod_s1);
			P_INIT_F: acc_q <= RND_F + prod_sh;
			P_INIT_M: acc_q <= RND_M + prod_sh;
			P_ADD:    acc_q <= acc_q + prod_sh;
			default:  ;
		endcase
		if (in_fire)
			x0_q <= sample_in;
		if (ctrl.yset)
			y_q <= y_cl;
		if (out_go)
			out_q <= s_cl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pact_s1     <= P_NONE;
			sh_s1       <= SH_0;
			x1_q        <= '0;
			x2_q        <= '0;
			y1_q        <= '0;
			y2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pact_s1 <= ctrl.pact;
			sh_s1   <= ctrl.sh;
			if (out_go) begin
				x2_q        <= x1_q;
				x1_q        <= x0_q;
				y2_q        <= y1_q;
				y1_q        <= y_q;
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sample_out = out_q;
	assign out_valid  = out_valid_q;

endmodule

>>> rtl/allpass_notch_filter_mix.sv
// Notch filter from a second-order allpass section with wet/dry mix, for one audio
// channel. Each request on s_axis carries a signed 16-bit sample; one mixed, saturated
// sample leaves on m_axis per request. A microcoded sequencer drives a single shared
// multiplier through an eleven-step program, one wait step and ten working steps; the
// result is registered in the last step once the output is free, and a new sample
// is taken only once the previous result has been registered, even if it has not
// yet been read. c, d and the mix are signed/unsigned Q.COEF_FRAC_BITS and Q14 values
// written through cfg_*; write them only while no sample is in flight. Mix values
// above 16384 act as 16384.
module allpass_notch_filter_mix #(
	parameter int COEF_FRAC_BITS = anf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [anf_pkg::DATA_W-1:0]        s_axis_tdata,   // [15:0] sample_in
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [anf_pkg::DATA_W-1:0]        m_axis_tdata,   // [15:0] sample_out
	input  logic                              cfg_we,
	input  logic [anf_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [anf_pkg::DATA_W-1:0]        cfg_wdata
);
	import anf_pkg::*;

	logic signed [DATA_W-1:0] coef_c_q, coef_d_q;
	logic        [MIX_W-1:0]  wet_mix_q;
	ctrl_t                    ctrl;
	seq_stat_t                stat;
	logic                     in_fire;
	logic                     out_free;
	logic signed [DATA_W-1:0] sample_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_c_q  <= COEF_C_RST;
			coef_d_q  <= COEF_D_RST;
			wet_mix_q <= WET_MIX_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_COEF_C:  coef_c_q  <= $signed(cfg_wdata);
				REG_COEF_D:  coef_d_q  <= $signed(cfg_wdata);
				REG_WET_MIX: wet_mix_q <= cfg_wdata[MIX_W-1:0];
				default:     ;
			endcase
		end
	end

	assign s_axis_tready = (ctrl.jmp == J_WAIT);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign stat.in_req   = s_axis_tvalid;
	assign stat.out_free = out_free;

	anf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	anf_dp #(
		.F (COEF_FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.in_fire    (in_fire),
		.sample_in  ($signed(s_axis_tdata)),
		.coef_c     (coef_c_q),
		.coef_d     (coef_d_q),
		.wet_mix    (wet_mix_q),
		.out_take   (m_axis_tready),
		.sample_out (sample_out),
		.out_valid  (m_axis_tvalid),
		.out_free   (out_free)
	);

	assign m_axis_tdata = sample_out;

endmodule
